/* src/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg: shared constants and helpers for the polar/rectangular converter
// Holds the internal datapath widths, the CORDIC gain correction, the
// arctangent table generator and the saturation helpers.
// ----------------------------------------------------------------------------
package prc_pkg;

    // Internal coordinate width: Q16.16 scaled by 2^GUARD plus CORDIC growth.
    localparam int XW    = 60;
    // Internal angle width: degrees with 32 fraction bits, plus headroom.
    localparam int ZW    = 44;
    localparam int GUARD = 24;
    // Result width of the gain correction before saturation.
    localparam int GW    = 36;

    // Reciprocal of the CORDIC gain, 0.60725293500888 in Q32.
    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    // 180/pi in Q32.
    localparam logic [63:0] RAD2DEG  = 64'd246083499208;

    // Form selector codes.
    localparam logic [1:0] FORM_RECT  = 2'd0;
    localparam logic [1:0] FORM_POLAR = 2'd1;

    // Restoring division, used only while building constants.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], n[j]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees Q32, from the arctangent series in radians Q62.
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        int           sh;
        acc = '0;
        if (i == 0) begin
            return ZW'(64'd45 << 32);
        end
        for (int k = 0; k < 32; k++) begin
            sh = 62 - (2 * k + 1) * i;
            if (sh >= 0) begin
                term = udiv64(64'd1 << sh, 64'(2 * k + 1));
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        prod = 128'(acc) * 128'(RAD2DEG) + (128'd1 << 61);
        return ZW'(prod >> 62);
    endfunction

    // Saturate a gain-corrected value to the signed 32-bit range.
    function automatic logic signed [31:0] sat_s32(input logic signed [GW-1:0] v);
        if (v > GW'(64'sd2147483647)) begin
            return 32'sh7FFFFFFF;
        end else if (v < -GW'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // Saturate a non-negative gain-corrected value to the unsigned 32-bit range.
    function automatic logic [31:0] sat_u32(input logic signed [GW-1:0] v);
        if (v[GW-1]) begin
            return '0;
        end else if (v > GW'(64'sd4294967295)) begin
            return 32'hFFFFFFFF;
        end
        return 32'(v);
    endfunction

endpackage

/* src/prc_cordic_stage.sv */
// ----------------------------------------------------------------------------
// prc_cordic_stage: one registered CORDIC micro-rotation
// Rotation mode steers on the sign of the residual angle, vectoring mode on
// the sign of y. Shift and arctangent constant follow from the stage index.
// ----------------------------------------------------------------------------
module prc_cordic_stage #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [prc_pkg::XW-1:0]   i_x,
    input  logic signed [prc_pkg::XW-1:0]   i_y,
    input  logic signed [prc_pkg::ZW-1:0]   i_z,
    output logic signed [prc_pkg::XW-1:0]   o_x,
    output logic signed [prc_pkg::XW-1:0]   o_y,
    output logic signed [prc_pkg::ZW-1:0]   o_z
);

    localparam logic signed [prc_pkg::ZW-1:0] ATAN = prc_pkg::atan_deg(STAGE);

    logic                          n_dir;
    logic signed [prc_pkg::XW-1:0] dx;
    logic signed [prc_pkg::XW-1:0] dy;

    // Direction of this micro-rotation.
    always_comb begin
        n_dir = VECTORING ? i_y[prc_pkg::XW-1] : !i_z[prc_pkg::ZW-1];
        dx    = i_y >>> STAGE;
        dy    = i_x >>> STAGE;
    end

    // Add/subtract and register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_dir) begin
                o_x <= i_x - dx;
                o_y <= i_y + dy;
                o_z <= i_z - ATAN;
            end else begin
                o_x <= i_x + dx;
                o_y <= i_y - dy;
                o_z <= i_z + ATAN;
            end
        end
    end

endmodule

/* src/prc_gain.sv */
// ----------------------------------------------------------------------------
// prc_gain: CORDIC gain removal
// Multiplies by 1/K in Q32 and drops the guard and fraction bits with
// rounding half away from zero. Three stages: split product, sum, sign.
// ----------------------------------------------------------------------------
module prc_gain (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [prc_pkg::XW-1:0]   i_val,
    input  logic                            i_flip,
    output logic signed [prc_pkg::GW-1:0]   o_res
);

    localparam int SH = 32 + prc_pkg::GUARD;
    localparam int HB = 29;
    localparam int PW = HB + 32;
    localparam int SW = 2 * HB + 32 + 1;

    logic [prc_pkg::XW-1:0] mag;
    logic [PW-1:0]          r_plo;
    logic [PW-1:0]          r_phi;
    logic                   r_neg1;
    logic [SW-1:0]          sum;
    logic [SW-SH-1:0]       r_abs;
    logic                   r_neg2;

    // Magnitude of the input; the sign is handled apart.
    always_comb begin
        mag = i_val[prc_pkg::XW-1] ? prc_pkg::XW'(-i_val) : prc_pkg::XW'(i_val);
    end

    // Stage 1: two partial products of the magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo  <= PW'(mag[HB-1:0]) * PW'(prc_pkg::INV_GAIN);
            r_phi  <= PW'(mag[2*HB-1:HB]) * PW'(prc_pkg::INV_GAIN);
            r_neg1 <= i_val[prc_pkg::XW-1] ^ i_flip;
        end
    end

    // Stage 2: combine, round and shift down.
    always_comb begin
        sum = (SW'(r_phi) << HB) + SW'(r_plo) + (SW'(1) << (SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= sum[SW-1:SH];
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: restore the sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= r_neg2 ? -prc_pkg::GW'({1'b0, r_abs}) : prc_pkg::GW'({1'b0, r_abs});
        end
    end

endmodule

/* src/prc_rotate.sv */
// ----------------------------------------------------------------------------
// prc_rotate: polar to rectangular conversion
// Reduces the angle modulo 360 degrees by pipelined compare-subtract,
// folds it into the right half plane, rotates (m, 0) with a pipelined
// CORDIC and removes the gain with saturation to 32 bits.
// ----------------------------------------------------------------------------
module prc_rotate #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_mag,
    input  logic signed [25:0] i_ang,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);

    localparam int KB = (18 - FRAC_BITS > 1) ? 18 - FRAC_BITS : 1;
    localparam int AW = 36;
    localparam int XW = prc_pkg::XW;
    localparam int ZW = prc_pkg::ZW;
    localparam logic signed [AW-1:0] FULL    = AW'(64'sd360 <<< FRAC_BITS);
    localparam logic signed [AW-1:0] HALF    = AW'(64'sd180 <<< FRAC_BITS);
    localparam logic signed [AW-1:0] QUARTER = AW'(64'sd90 <<< FRAC_BITS);

    logic        [25:0]    ang_abs;
    logic        [25:0]    r_rem [KB];
    logic                  r_sgn [KB];
    logic signed [31:0]    r_m   [KB];

    logic signed [AW-1:0]  zr;
    logic signed [AW-1:0]  n_z1;
    logic signed [AW-1:0]  r_z1;
    logic signed [31:0]    r_m1;

    logic signed [AW-1:0]  n_z2;
    logic                  n_flip;
    logic signed [XW-1:0]  r_x2;
    logic signed [ZW-1:0]  r_z2;
    logic                  r_flip2;

    logic signed [XW-1:0]  cx [CORDIC_STAGES+1];
    logic signed [XW-1:0]  cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0]  cz [CORDIC_STAGES+1];
    logic                  r_fl [CORDIC_STAGES];

    logic signed [prc_pkg::GW-1:0] gx;
    logic signed [prc_pkg::GW-1:0] gy;

    // Angle magnitude; the remainder takes the sign of the angle.
    always_comb begin
        ang_abs = i_ang[25] ? 26'(-i_ang) : 26'(i_ang);
    end

    // Remainder by 360 degrees, one multiple of 360 tried per stage.
    for (genvar k = 0; k < KB; k++) begin : g_mod
        localparam logic [33:0] DIV = 34'(64'd360 << (FRAC_BITS + KB - 1 - k));
        logic [25:0] rem_in;
        logic        sgn_in;
        logic signed [31:0] m_in;

        if (k == 0) begin : g_first
            always_comb begin
                rem_in = ang_abs;
                sgn_in = i_ang[25];
                m_in   = i_mag;
            end
        end else begin : g_next
            always_comb begin
                rem_in = r_rem[k-1];
                sgn_in = r_sgn[k-1];
                m_in   = r_m[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (34'(rem_in) >= DIV) begin
                    r_rem[k] <= 26'(34'(rem_in) - DIV);
                end else begin
                    r_rem[k] <= rem_in;
                end
                r_sgn[k] <= sgn_in;
                r_m[k]   <= m_in;
            end
        end
    end

    // Wrap the signed remainder into [-180, 180).
    always_comb begin
        zr = r_sgn[KB-1] ? -AW'(r_rem[KB-1]) : AW'(r_rem[KB-1]);
        if (zr >= HALF) begin
            n_z1 = zr - FULL;
        end else if (zr < -HALF) begin
            n_z1 = zr + FULL;
        end else begin
            n_z1 = zr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= n_z1;
            r_m1 <= r_m[KB-1];
        end
    end

    // Fold into [-90, 90] by a half turn; the result is negated later.
    always_comb begin
        n_flip = 1'b0;
        n_z2   = r_z1;
        if (r_z1 > QUARTER) begin
            n_z2   = r_z1 - HALF;
            n_flip = 1'b1;
        end else if (r_z1 < -QUARTER) begin
            n_z2   = r_z1 + HALF;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z2    <= ZW'(n_z2) <<< (32 - FRAC_BITS);
            r_x2    <= {{(XW - 32 - prc_pkg::GUARD){r_m1[31]}}, r_m1, {prc_pkg::GUARD{1'b0}}};
            r_flip2 <= n_flip;
        end
    end

    // Rotation CORDIC.
    assign cx[0] = r_x2;
    assign cy[0] = '0;
    assign cz[0] = r_z2;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        prc_cordic_stage #(
            .STAGE     (i),
            .VECTORING (1'b0)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (cx[i]),
            .i_y   (cy[i]),
            .i_z   (cz[i]),
            .o_x   (cx[i+1]),
            .o_y   (cy[i+1]),
            .o_z   (cz[i+1])
        );

        if (i == 0) begin : g_fl0
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_fl[i] <= r_flip2;
                end
            end
        end else begin : g_fln
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_fl[i] <= r_fl[i-1];
                end
            end
        end
    end

    // Gain removal on both coordinates.
    prc_gain u_gain_x (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (cx[CORDIC_STAGES]),
        .i_flip (r_fl[CORDIC_STAGES-1]),
        .o_res  (gx)
    );

    prc_gain u_gain_y (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (cy[CORDIC_STAGES]),
        .i_flip (r_fl[CORDIC_STAGES-1]),
        .o_res  (gy)
    );

    // Saturate to 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= prc_pkg::sat_s32(gx);
            o_y <= prc_pkg::sat_s32(gy);
        end
    end

endmodule

/* src/prc_vector.sv */
// ----------------------------------------------------------------------------
// prc_vector: rectangular to magnitude and angle
// Moves the vector into the right half plane, runs a pipelined vectoring
// CORDIC, then rounds the angle to the output format and removes the gain
// from the magnitude. The zero vector gives zero for both.
// ----------------------------------------------------------------------------
module prc_vector #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    output logic        [31:0] o_mag,
    output logic signed [24:0] o_ang
);

    localparam int XW = prc_pkg::XW;
    localparam int ZW = prc_pkg::ZW;
    localparam int S  = 32 - FRAC_BITS;
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'sd180 <<< 32);
    localparam logic signed [ZW-1:0] RND    = ZW'(64'sd1 <<< (S - 1));
    localparam logic signed [ZW-1:0] AMAX   = ZW'(64'sd16777215);
    localparam logic signed [ZW-1:0] AMIN   = -ZW'(64'sd16777216);

    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic signed [XW-1:0] r_x0;
    logic signed [XW-1:0] r_y0;
    logic signed [ZW-1:0] r_base0;
    logic                 r_zero0;

    logic signed [XW-1:0] cx [CORDIC_STAGES+1];
    logic signed [XW-1:0] cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
    logic signed [ZW-1:0] r_bd [CORDIC_STAGES];
    logic                 r_zd [CORDIC_STAGES];

    logic signed [ZW-1:0] zsum;
    logic signed [ZW-1:0] r_za;
    logic signed [ZW-1:0] r_tb;
    logic signed [24:0]   r_ang;
    logic                 r_zero_a;
    logic                 r_zero_b;
    logic                 r_zero_c;
    logic signed [prc_pkg::GW-1:0] gm;

    // Scale up and mirror a left half plane vector, noting the base angle.
    always_comb begin
        xe = {{(XW - 32 - prc_pkg::GUARD){i_x[31]}}, i_x, {prc_pkg::GUARD{1'b0}}};
        ye = {{(XW - 32 - prc_pkg::GUARD){i_y[31]}}, i_y, {prc_pkg::GUARD{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero0 <= (i_x == '0) && (i_y == '0);
            if (i_x[31]) begin
                r_x0    <= -xe;
                r_y0    <= -ye;
                r_base0 <= i_y[31] ? -DEG180 : DEG180;
            end else begin
                r_x0    <= xe;
                r_y0    <= ye;
                r_base0 <= '0;
            end
        end
    end

    // Vectoring CORDIC with the base angle and zero flag alongside.
    assign cx[0] = r_x0;
    assign cy[0] = r_y0;
    assign cz[0] = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        prc_cordic_stage #(
            .STAGE     (i),
            .VECTORING (1'b1)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (cx[i]),
            .i_y   (cy[i]),
            .i_z   (cz[i]),
            .o_x   (cx[i+1]),
            .o_y   (cy[i+1]),
            .o_z   (cz[i+1])
        );

        if (i == 0) begin : g_d0
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_bd[i] <= r_base0;
                    r_zd[i] <= r_zero0;
                end
            end
        end else begin : g_dn
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_bd[i] <= r_bd[i-1];
                    r_zd[i] <= r_zd[i-1];
                end
            end
        end
    end

    // Angle: add the base and clamp to plus or minus 180 degrees.
    always_comb begin
        zsum = cz[CORDIC_STAGES] + r_bd[CORDIC_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (zsum > DEG180) begin
                r_za <= DEG180;
            end else if (zsum < -DEG180) begin
                r_za <= -DEG180;
            end else begin
                r_za <= zsum;
            end
            r_zero_a <= r_zd[CORDIC_STAGES-1];
        end
    end

    // Angle: round half up to the output fraction.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tb     <= (r_za + RND) >>> S;
            r_zero_b <= r_zero_a;
        end
    end

    // Angle: clamp to the 25-bit output range.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_tb > AMAX) begin
                r_ang <= 25'(AMAX);
            end else if (r_tb < AMIN) begin
                r_ang <= 25'(AMIN);
            end else begin
                r_ang <= 25'(r_tb);
            end
            r_zero_c <= r_zero_b;
        end
    end

    // Magnitude gain removal runs beside the three angle stages.
    prc_gain u_gain_m (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (cx[CORDIC_STAGES]),
        .i_flip (1'b0),
        .o_res  (gm)
    );

    // Final register with the zero vector forced to zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag <= r_zero_c ? '0 : prc_pkg::sat_u32(gm);
            o_ang <= r_zero_c ? '0 : r_ang;
        end
    end

endmodule

/* src/polar_rect_vector_convert_top.sv */
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits in the output register.
// Reset (i_rst_n low, synchronous) clears only the valid bits; data is not reset.
// ----------------------------------------------------------------------------
// polar_rect_vector_convert_top: polar/rectangular vector converter
// Polar items pass through a rotation CORDIC; every valid vector then goes
// through a vectoring CORDIC for its length and angle. Invalid forms give
// zero outputs and the error flag.
// ----------------------------------------------------------------------------
module polar_rect_vector_convert_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] first_value, [57:32] second_value, [63:58] zero
    input  logic [63:0]  i_s_tdata,
    // [1:0] form_sel
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] x_coord, [63:32] y_coord, [95:64] magnitude, [120:96] angle_deg,
    // [127:121] zero
    output logic [127:0] o_m_tdata,
    // [0] form_error
    output logic [0:0]   o_m_tuser
);

    localparam int KB = (18 - FRAC_BITS > 1) ? 18 - FRAC_BITS : 1;
    localparam int LR = KB + 2 + CORDIC_STAGES + 4;
    localparam int LV = CORDIC_STAGES + 5;
    localparam int L  = LR + LV;

    typedef struct packed {
        logic [1:0]   form;
        logic [31:0]  a;
        logic [25:0]  b;
    } t_front;

    typedef struct packed {
        logic [31:0]  x;
        logic [31:0]  y;
        logic         err;
    } t_back;

    logic          en;
    logic          r_vld [L];
    t_front        fin;
    t_front        r_fr [LR];
    t_back         bsel;
    t_back         r_bk [LV];
    logic [31:0]   rot_x;
    logic [31:0]   rot_y;
    logic [31:0]   vec_mag;
    logic [24:0]   vec_ang;

    // The pipeline moves when the output register is empty or being taken.
    assign en         = !r_vld[L-1] || i_m_tready;
    assign o_s_tready = en;

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < L; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Unpack the input transfer.
    always_comb begin
        fin.form = i_s_tuser;
        fin.a    = i_s_tdata[31:0];
        fin.b    = i_s_tdata[57:32];
    end

    // Polar to rectangular.
    prc_rotate #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_rotate (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (fin.a),
        .i_ang (fin.b),
        .o_x   (rot_x),
        .o_y   (rot_y)
    );

    // Form and raw values wait for the rotation result.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fr[0] <= fin;
            for (int i = 1; i < LR; i++) begin
                r_fr[i] <= r_fr[i-1];
            end
        end
    end

    // Choose the rectangular vector by form.
    always_comb begin
        bsel = '0;
        unique case (r_fr[LR-1].form)
            prc_pkg::FORM_RECT: begin
                bsel.x = r_fr[LR-1].a;
                bsel.y = 32'(signed'(r_fr[LR-1].b));
            end
            prc_pkg::FORM_POLAR: begin
                bsel.x = rot_x;
                bsel.y = rot_y;
            end
            default: begin
                bsel.err = 1'b1;
            end
        endcase
    end

    // Rectangular to length and angle.
    prc_vector #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_vector (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (bsel.x),
        .i_y   (bsel.y),
        .o_mag (vec_mag),
        .o_ang (vec_ang)
    );

    // Coordinates and error flag wait for the vectoring result.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bk[0] <= bsel;
            for (int i = 1; i < LV; i++) begin
                r_bk[i] <= r_bk[i-1];
            end
        end
    end

    // Output transfer.
    assign o_m_tvalid = r_vld[L-1];
    assign o_m_tdata  = {7'b0, vec_ang, vec_mag, r_bk[LV-1].y, r_bk[LV-1].x};
    assign o_m_tuser  = r_bk[LV-1].err;

endmodule

/* test/polar_rect_vector_convert_top_tb.sv */
// ----------------------------------------------------------------------------
// polar_rect_vector_convert_top_tb: self-checking bench for the converter
// A queue of input transfers feeds a clocked driver that inserts random gaps.
// A clocked monitor stalls at random and checks every output transfer, field
// by field, against a bit-exact fixed-point CORDIC predictor of its own.
// ----------------------------------------------------------------------------
module polar_rect_vector_convert_top_tb;

    localparam int  STAGES     = 16;
    localparam int  FRAC       = 16;
    localparam int  GUARD_BITS = 24;
    localparam int  DRAIN_WAIT = 60;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  N_RANDOM   = 1150;
    localparam logic [1:0] FORM_BAD2 = 2'd2;
    localparam logic [1:0] FORM_BAD3 = 2'd3;
    localparam longint DEG        = 64'sd1 << 32;
    localparam longint unsigned DEG_PER_RADIAN = 64'd246083499208;
    localparam longint unsigned GAIN_COMP  = 64'd2608131496;
    localparam int  ANGLE_SPAN = 23592960;

    typedef struct {
        logic [1:0]         form;
        logic signed [31:0] first;
        logic signed [25:0] second;
        bit                 hold;
    } t_vec_in;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        mag;
        logic signed [24:0] ang;
        logic               err;
    } t_vec_out;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [1:0]   s_tuser = prc_pkg::FORM_RECT;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    t_vec_in  pending_vecs[$];
    t_vec_out expected_vecs[$];
    t_vec_in  cur_vec;
    longint   atan_q32[STAGES];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       form_count[4] = '{0, 0, 0, 0};
    int       results_seen = 0;

    polar_rect_vector_convert_top #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (FRAC)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    // Clock with a period of 10 units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Rounded (|a| * b) >> s with the sign of a restored afterwards.
    function automatic longint scale_round(longint a, longint unsigned b, int s);
        logic [127:0] prod;
        bit           neg;
        neg  = a < 0;
        prod = 128'(neg ? -a : a) * 128'(b) + (128'd1 << (s - 1));
        prod = prod >> s;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Arctangent table in degrees Q32 from the series in radians Q62.
    initial begin
        longint unsigned acc;
        longint unsigned term;
        logic [127:0]    prod;
        int              sh;
        atan_q32[0] = 45 * DEG;
        for (int i = 1; i < STAGES; i++) begin
            acc = 0;
            for (int k = 0; 62 - (2 * k + 1) * i >= 0; k++) begin
                sh   = 62 - (2 * k + 1) * i;
                term = (64'd1 << sh) / longint'(2 * k + 1);
                acc  = k[0] ? acc - term : acc + term;
            end
            prod        = 128'(acc) * 128'(DEG_PER_RADIAN) + (128'd1 << 61);
            atan_q32[i] = longint'(prod >> 62);
        end
    end

    // Expected result of one conversion.
    function automatic t_vec_out convert_vec(t_vec_in v);
        t_vec_out r;
        longint   x, y, z, dx, dy, vx, vy, base;
        bit       flip;
        r = '{x: 0, y: 0, mag: 0, ang: 0, err: 0};
        if (v.form != prc_pkg::FORM_RECT && v.form != prc_pkg::FORM_POLAR) begin
            r.err = 1'b1;
            return r;
        end
        if (v.form == prc_pkg::FORM_RECT) begin
            vx = v.first;
            vy = v.second;
        end else begin
            // Reduce the angle to [-180, 180), then fold into [-90, 90].
            z    = longint'(v.second) <<< (32 - FRAC);
            flip = 0;
            z    = z % (360 * DEG);
            if (z >= 180 * DEG) z -= 360 * DEG;
            if (z < -180 * DEG) z += 360 * DEG;
            if (z > 90 * DEG) begin
                z -= 180 * DEG;
                flip = 1;
            end else if (z < -90 * DEG) begin
                z += 180 * DEG;
                flip = 1;
            end
            x = longint'(v.first) <<< GUARD_BITS;
            y = 0;
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q32[i];
                end else begin
                    x += dx; y -= dy; z += atan_q32[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            vx = clamp(scale_round(x, GAIN_COMP, 32 + GUARD_BITS), -(64'sd1 << 31),
                       (64'sd1 << 31) - 1);
            vy = clamp(scale_round(y, GAIN_COMP, 32 + GUARD_BITS), -(64'sd1 << 31),
                       (64'sd1 << 31) - 1);
        end
        r.x = vx[31:0];
        r.y = vy[31:0];
        if (vx == 0 && vy == 0) return r;
        // Vectoring pass: the left half plane is mirrored first.
        base = 0;
        z    = 0;
        x    = vx <<< GUARD_BITS;
        y    = vy <<< GUARD_BITS;
        if (vx < 0) begin
            x    = -x;
            y    = -y;
            base = vy >= 0 ? 180 * DEG : -180 * DEG;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_q32[i];
            end else begin
                x += dx; y -= dy; z += atan_q32[i];
            end
        end
        z     = clamp(z + base, -180 * DEG, 180 * DEG);
        z     = (z + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC);
        z     = clamp(z, -(64'sd1 << 24), (64'sd1 << 24) - 1);
        r.ang = z[24:0];
        x     = clamp(scale_round(x, GAIN_COMP, 32 + GUARD_BITS), 0, 64'sd4294967295);
        r.mag = x[31:0];
        return r;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    // Input side: loads queued vectors, waits out random gaps and hold points.
    always @(posedge i_clk) begin
        static int gap = 0;
        bit        busy;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                expected_vecs.push_back(convert_vec(cur_vec));
                form_count[cur_vec.form]++;
            end
            if (!busy) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_vecs.size() > 0 &&
                             !(pending_vecs[0].hold && expected_vecs.size() > 0)) begin
                    cur_vec = pending_vecs.pop_front();
                    s_tdata  <= {6'd0, cur_vec.second, cur_vec.first};
                    s_tuser  <= cur_vec.form;
                    s_tvalid <= 1'b1;
                    gap = draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls and a field-by-field check of every transfer.
    always @(posedge i_clk) begin
        static int stall = 0;
        t_vec_out  exp_v;
        t_vec_out  got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.x   = m_tdata[31:0];
                got.y   = m_tdata[63:32];
                got.mag = m_tdata[95:64];
                got.ang = m_tdata[120:96];
                got.err = m_tuser[0];
                if (expected_vecs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output transfer: x=%0d y=%0d", got.x, got.y);
                end else begin
                    exp_v = expected_vecs.pop_front();
                    if (got.x !== exp_v.x || got.y !== exp_v.y || got.mag !== exp_v.mag ||
                        got.ang !== exp_v.ang || got.err !== exp_v.err ||
                        m_tdata[127:121] !== 7'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: exp x=%0d y=%0d mag=%0d ang=%0d err=%0b,",
                                     exp_v.x, exp_v.y, exp_v.mag, exp_v.ang, exp_v.err);
                            $display("          got x=%0d y=%0d mag=%0d ang=%0d err=%0b",
                                     got.x, got.y, got.mag, got.ang, got.err);
                        end
                    end
                end
                stall = draw_gap();
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired");
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_vec(logic [1:0] form, logic signed [31:0] a, logic signed [25:0] b,
                           bit hold = 0);
        pending_vecs.push_back('{form: form, first: a, second: b, hold: hold});
    endtask

    // Stimulus and end of run.
    initial begin
        int      r;
        logic [1:0] f;
        i_rst_n     = 1'b0;

        // Directed: zero vector, axis cases, extremes, angle wrap and bad forms.
        add_vec(prc_pkg::FORM_RECT, 0, 0);
        add_vec(prc_pkg::FORM_RECT, -32'sd65536, 0);
        add_vec(prc_pkg::FORM_RECT, 32'sh7FFFFFFF, 26'sh1FFFFFF);
        add_vec(prc_pkg::FORM_RECT, 32'sh80000000, -26'sh2000000);
        add_vec(prc_pkg::FORM_RECT, 32'sh80000000, 0);
        add_vec(prc_pkg::FORM_RECT, 0, -26'sd65536);
        add_vec(prc_pkg::FORM_POLAR, 0, 26'sd2949120);
        add_vec(prc_pkg::FORM_POLAR, 32'sd65536, 26'(ANGLE_SPAN));
        add_vec(prc_pkg::FORM_POLAR, 32'sd65536, 26'(-ANGLE_SPAN));
        add_vec(prc_pkg::FORM_POLAR, 32'sd655360, 26'(180 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sd655360, 26'(-180 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sd655360, 26'(90 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sd655360, 26'(-90 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sd655360, 26'(270 * 65536));
        add_vec(prc_pkg::FORM_POLAR, -32'sd655360, 26'(30 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sh7FFFFFFF, 26'(45 * 65536));
        add_vec(prc_pkg::FORM_POLAR, 32'sh80000000, 26'(-135 * 65536));
        add_vec(FORM_BAD2, 32'sh7FFFFFFF, 26'sh1FFFFFF);
        add_vec(FORM_BAD3, 32'sh80000000, -26'sh2000000);
        add_vec(prc_pkg::FORM_RECT, 32'sd12345, 26'sd54321, 1);

        // Random: mostly valid forms, full-range first values, a few bad forms.
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 19);
            f = r < 9 ? prc_pkg::FORM_RECT :
                (r < 18 ? prc_pkg::FORM_POLAR : 2'($urandom_range(2, 3)));
            add_vec(f, $urandom,
                    f == prc_pkg::FORM_RECT && $urandom_range(0, 1) ? 26'($urandom) :
                    26'(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN),
                    n == N_RANDOM / 2);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_vecs.size() == 0);
        @(posedge i_clk);
        while (s_tvalid) @(posedge i_clk);
        while (expected_vecs.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Converted %0d rectangular, %0d polar and %0d invalid-form vectors,",
                 form_count[0], form_count[1], form_count[2] + form_count[3]);
        $display("with %0d results checked and %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/prc_pkg.sv
src/prc_cordic_stage.sv
src/prc_gain.sv
src/prc_rotate.sv
src/prc_vector.sv
src/polar_rect_vector_convert_top.sv
test/polar_rect_vector_convert_top_tb.sv
